/* hw/rtl/itpc_pkg.sv */
package itpc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FRONT, ST_PUSHL, ST_BODY, ST_RD, ST_CHK,
    ST_FN_RD, ST_FN_CHK, ST_STATUS, ST_DONE
  } state_t;

  typedef enum logic [1:0] {M_RPAR, M_OP, M_END} mode_t;

  typedef struct packed {
    logic        bad;
    logic [4:0]  places;
    logic [59:0] mant;
    logic [2:0]  fidx;
    logic [3:0]  kind;
  } tok_t;

  localparam logic [3:0] K_NUM    = 4'd0;
  localparam logic [3:0] K_VAR    = 4'd1;
  localparam logic [3:0] K_ADD    = 4'd2;
  localparam logic [3:0] K_SUB    = 4'd3;
  localparam logic [3:0] K_MUL    = 4'd4;
  localparam logic [3:0] K_DIV    = 4'd5;
  localparam logic [3:0] K_POW    = 4'd6;
  localparam logic [3:0] K_FUNC   = 4'd7;
  localparam logic [3:0] K_STATUS = 4'd8;

  localparam logic [3:0] CODE_FUNC = 4'd8;
  localparam logic [3:0] CODE_FEND = 4'd14;
  localparam logic [3:0] CODE_LPAR = 4'd15;

  localparam logic [59:0] MANT_MAX     = 60'd999999999999999999;
  localparam logic [4:0]  PLACES_MAX   = 5'd18;
  localparam logic [4:0]  RESULT_LIMIT = 5'd19;

  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;

  function automatic logic [1:0] prec(input logic [3:0] code);
    case (code)
      K_ADD, K_SUB: prec = 2'd1;
      K_MUL, K_DIV: prec = 2'd2;
      K_POW:        prec = 2'd3;
      default:      prec = 2'd0;
    endcase
  endfunction

  function automatic logic [3:0] op_code(input logic [7:0] c);
    case (c)
      CH_PLUS:  op_code = K_ADD;
      CH_MINUS: op_code = K_SUB;
      CH_STAR:  op_code = K_MUL;
      CH_SLASH: op_code = K_DIV;
      CH_CARET: op_code = K_POW;
      default:  op_code = 4'd0;
    endcase
  endfunction

  // Turn a stack code into a result item.
  function automatic tok_t code_tok(input logic [3:0] code);
    tok_t t;
    t = '0;
    if (code >= CODE_FUNC && code < CODE_FEND) begin
      t.kind = K_FUNC;
      t.fidx = 3'(code - CODE_FUNC);
    end else begin
      t.kind = code;
    end
    return t;
  endfunction

  // Match a letter run against the function names; returns {hit, index}.
  function automatic logic [3:0] fn_match(input logic [31:0] l, input logic [3:0] len);
    logic [3:0] r;
    r = 4'd0;
    if (len == 4'd3) begin
      case (l[31:8])
        24'("sin"): r = 4'b1000;
        24'("cos"): r = 4'b1001;
        24'("tan"): r = 4'b1010;
        24'("ctg"): r = 4'b1011;
        default:    r = 4'd0;
      endcase
    end else if (len == 4'd4 && l == 32'("sqrt")) begin
      r = 4'b1100;
    end else if (len == 4'd2 && l[31:16] == 16'("ln")) begin
      r = 4'b1101;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter.sv */
// Infix to postfix converter (shunting-yard). Send an expression one ASCII
// character per input item with tlast low; send an item with tlast high to
// end it. Each character yields zero or more postfix tokens (numbers as a
// decimal mantissa plus place count, the variable x, operators + - * / ^ with
// precedence 1,1,2,2,3 all left-associative, and sin cos tan ctg sqrt ln which
// must be followed at once by '('); the end item flushes the operator stack
// and yields a status token with malformed set when the expression was
// rejected. tlast on the output marks the last token caused by one input item.
// After an error further characters give nothing until the end item. The
// operator stack lives in a synchronous memory with a registered read. A
// character passes through a front step and a body step (a letter only the
// front step; the '(' of a function call takes a push step in place of the
// body). An operator or ')' examines stack entries one by one, an address
// step and then a data step for each; a ')' that finds its '(' then looks
// for the owning function below it. The end item flushes the stack in the
// same way and then emits the status token; a stalled output makes it wait.
module infix_to_postfix_converter
  import itpc_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_MAX    = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] function_index, [62:3] mantissa, [67:63] decimal_places,
  // [68] malformed, [71:69] zero
  output logic [71:0] m_tdata,
  output logic [3:0]  m_tuser,   // [3:0] token_kind
  output logic        m_tlast    // last_of_run
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int NW  = $clog2(NAME_MAX + 1);
  localparam int LIW = $clog2(NAME_MAX);

  // stack memory
  logic [3:0]    stack_mem [STACK_DEPTH];
  logic [3:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [3:0]    wdata;

  always_ff @(posedge clk) begin
    if (we) stack_mem[waddr] <= wdata;
    rdata <= stack_mem[raddr];
  end

  // control and pending-token state
  state_t      state, state_next;
  mode_t       mode, mode_next;
  logic [7:0]  ch;
  logic        eot;
  logic [CW-1:0] count, count_next;
  logic [59:0] digits, digits_next;
  logic [4:0]  frac, frac_next;
  logic [2:0]  flags, flags_next;        // bit0 pending, bit1 point, bit2 digit
  logic [7:0]  letters [NAME_MAX];
  logic        let_we;
  logic [NW-1:0] name_len, name_len_next;
  logic        err, err_next;
  logic [4:0]  rcnt;
  tok_t        pend, res, tok;
  logic        pend_v;
  logic        res_last;

  logic        emit_req, eff_emit, out_free, stall, load_out;

  // character classes
  logic        is_letter, is_digit, is_ws;
  logic [3:0]  opc;
  logic [3:0]  fm;
  logic        name_is_x;
  logic [63:0] mul10;
  logic        num_err;
  logic        num_emit;

  assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit  = ch >= 8'h30 && ch <= 8'h39;
  assign is_ws     = ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13);
  assign opc       = op_code(ch);
  assign fm        = fn_match({letters[0], letters[1], letters[2], letters[3]}, 4'(name_len));
  assign name_is_x = name_len == NW'(1) && letters[0] == CH_X;
  assign mul10     = ({4'd0, digits} << 3) + ({4'd0, digits} << 1) + 64'(ch - 8'h30);
  // closing a pending number: a run of points only is an error
  assign num_err   = flags[0] && !flags[2];
  assign num_emit  = flags[0] && flags[2] && !err;

  assign out_free  = !m_tvalid || m_tready;
  assign eff_emit  = emit_req && rcnt < RESULT_LIMIT;
  assign stall     = eff_emit && pend_v && !out_free;
  assign s_tready  = state == ST_IDLE;
  // move the held token into the output register
  assign load_out  = pend_v && ((!stall && eff_emit) || (state == ST_DONE && out_free));

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    count_next    = count;
    digits_next   = digits;
    frac_next     = frac;
    flags_next    = flags;
    name_len_next = name_len;
    err_next      = err;
    let_we        = 1'b0;
    emit_req      = 1'b0;
    tok           = '0;
    we            = 1'b0;
    waddr         = count[AW-1:0];
    wdata         = CODE_LPAR;
    raddr         = AW'(count - CW'(1));

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_FRONT;
      end
      ST_FRONT: begin
        if (eot) begin
          // close the pending number or letter run; at most one is pending
          if (num_err) err_next = 1'b1;
          if (num_emit) begin
            emit_req   = 1'b1;
            tok.kind   = K_NUM;
            tok.mant   = digits;
            tok.places = frac;
          end
          flags_next  = '0;
          digits_next = '0;
          frac_next   = '0;
          if (name_len != '0 && !err) begin
            if (name_is_x) begin
              emit_req = 1'b1;
              tok.kind = K_VAR;
            end else begin
              err_next = 1'b1;
            end
          end
          name_len_next = '0;
          mode_next     = M_END;
          state_next    = ST_RD;
        end else if (err) begin
          state_next = ST_DONE;
        end else if (is_letter) begin
          if (num_err) err_next = 1'b1;
          if (num_emit) begin
            emit_req   = 1'b1;
            tok.kind   = K_NUM;
            tok.mant   = digits;
            tok.places = frac;
          end
          flags_next  = '0;
          digits_next = '0;
          frac_next   = '0;
          if (!num_err) begin
            if (name_len >= NW'(NAME_MAX)) begin
              err_next = 1'b1;
            end else begin
              let_we        = 1'b1;
              name_len_next = name_len + NW'(1);
            end
          end
          state_next = ST_DONE;
        end else begin
          name_len_next = '0;
          if (name_len == '0) begin
            state_next = ST_BODY;
          end else if (name_is_x) begin
            emit_req   = 1'b1;
            tok.kind   = K_VAR;
            state_next = ST_BODY;
          end else if (fm[3]) begin
            if (ch == CH_LPAR && (CW + 1)'(count) + (CW + 1)'(2) <= (CW + 1)'(STACK_DEPTH)) begin
              we         = 1'b1;
              wdata      = CODE_FUNC + {1'b0, fm[2:0]};
              count_next = count + CW'(1);
              state_next = ST_PUSHL;
            end else begin
              err_next   = 1'b1;
              state_next = ST_DONE;
            end
          end else begin
            err_next   = 1'b1;
            state_next = ST_DONE;
          end
        end
      end
      ST_PUSHL: begin
        we         = 1'b1;
        count_next = count + CW'(1);
        state_next = ST_DONE;
      end
      ST_BODY: begin
        state_next = ST_DONE;
        if (is_digit || ch == CH_POINT) begin
          logic [2:0]  fl;
          logic [59:0] base;
          logic [4:0]  fr;
          fl   = flags[0] ? flags : 3'b001;
          base = flags[0] ? digits : '0;
          fr   = flags[0] ? frac : '0;
          if (ch == CH_POINT) begin
            if (fl[1]) err_next = 1'b1;
            else fl[1] = 1'b1;
          end else begin
            if (({4'd0, base} << 3) + ({4'd0, base} << 1) + 64'(ch - 8'h30) > {4'd0, MANT_MAX}) begin
              base     = MANT_MAX;
              err_next = 1'b1;
            end else begin
              base = mul10[59:0];
            end
            fl[2] = 1'b1;
            if (fl[1]) begin
              if (fr >= PLACES_MAX) err_next = 1'b1;
              else fr = fr + 5'd1;
            end
          end
          flags_next  = fl;
          digits_next = base;
          frac_next   = fr;
        end else begin
          if (num_err) err_next = 1'b1;
          if (num_emit) begin
            emit_req   = 1'b1;
            tok.kind   = K_NUM;
            tok.mant   = digits;
            tok.places = frac;
          end
          flags_next  = '0;
          digits_next = '0;
          frac_next   = '0;
          if (num_err || is_ws) begin
            state_next = ST_DONE;
          end else if (ch == CH_LPAR) begin
            if (count >= CW'(STACK_DEPTH)) begin
              err_next = 1'b1;
            end else begin
              we         = 1'b1;
              count_next = count + CW'(1);
            end
          end else if (ch == CH_RPAR) begin
            mode_next  = M_RPAR;
            state_next = ST_RD;
          end else if (opc != 4'd0) begin
            mode_next  = M_OP;
            state_next = ST_RD;
          end else begin
            err_next = 1'b1;
          end
        end
      end
      ST_RD: begin
        if (mode == M_END && (err || count == '0)) begin
          state_next = ST_STATUS;
        end else if (count == '0) begin
          if (mode == M_RPAR) begin
            err_next = 1'b1;
          end else begin
            we         = 1'b1;
            wdata      = opc;
            count_next = count + CW'(1);
          end
          state_next = ST_DONE;
        end else begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        unique case (mode)
          M_RPAR: begin
            count_next = count - CW'(1);
            if (rdata == CODE_LPAR) begin
              state_next = ST_FN_RD;
            end else begin
              emit_req   = 1'b1;
              tok        = code_tok(rdata);
              state_next = ST_RD;
            end
          end
          M_OP: begin
            if (rdata == CODE_LPAR || prec(rdata) < prec(opc)) begin
              if (count >= CW'(STACK_DEPTH)) begin
                err_next = 1'b1;
              end else begin
                we         = 1'b1;
                wdata      = opc;
                count_next = count + CW'(1);
              end
              state_next = ST_DONE;
            end else begin
              emit_req   = 1'b1;
              tok        = code_tok(rdata);
              count_next = count - CW'(1);
              state_next = ST_RD;
            end
          end
          default: begin
            if (rdata == CODE_LPAR) begin
              err_next   = 1'b1;
              state_next = ST_STATUS;
            end else begin
              emit_req   = 1'b1;
              tok        = code_tok(rdata);
              count_next = count - CW'(1);
              state_next = ST_RD;
            end
          end
        endcase
      end
      ST_FN_RD: begin
        state_next = (count == '0) ? ST_DONE : ST_FN_CHK;
      end
      ST_FN_CHK: begin
        // pop the function that owns this parenthesis, if there is one
        if (rdata >= CODE_FUNC && rdata < CODE_FEND) begin
          emit_req   = 1'b1;
          tok        = code_tok(rdata);
          count_next = count - CW'(1);
        end
        state_next = ST_DONE;
      end
      ST_STATUS: begin
        emit_req      = 1'b1;
        tok.kind      = K_STATUS;
        tok.bad       = err;
        count_next    = '0;
        err_next      = 1'b0;
        name_len_next = '0;
        flags_next    = '0;
        digits_next   = '0;
        frac_next     = '0;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        // release the held last token of this item
        if (!pend_v || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= M_END;
      count    <= '0;
      digits   <= '0;
      frac     <= '0;
      flags    <= '0;
      name_len <= '0;
      err      <= 1'b0;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
      rcnt     <= '0;
    end else begin
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (!stall) begin
        state    <= state_next;
        mode     <= mode_next;
        count    <= count_next;
        digits   <= digits_next;
        frac     <= frac_next;
        flags    <= flags_next;
        name_len <= name_len_next;
        err      <= err_next;
        if (eff_emit) begin
          pend_v <= 1'b1;
          rcnt   <= rcnt + 5'd1;
        end
      end
      if (state == ST_IDLE && s_tvalid) rcnt <= '0;
      if (state == ST_DONE && pend_v && out_free) pend_v <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      ch  <= s_tdata;
      eot <= s_tlast;
    end
    if (let_we && !stall) letters[name_len[LIW-1:0]] <= ch;
    if (!stall && eff_emit) begin
      if (pend_v) begin
        res      <= pend;
        res_last <= 1'b0;
      end
      pend <= tok;
    end
    if (state == ST_DONE && pend_v && out_free) begin
      res      <= pend;
      res_last <= 1'b1;
    end
  end

  assign m_tdata = {3'd0, res.bad, res.places, res.mant, res.fidx};
  assign m_tuser = res.kind;
  assign m_tlast = res_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v) else $error("token held while idle");
  a_limit: assert property (@(posedge clk) disable iff (rst)
    rcnt <= RESULT_LIMIT) else $error("too many tokens for one item");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_FRONT) else $error("accepted item not started");

endmodule
